### rtl/core/tccs_pkg.sv
// Shared types, field widths, character codes and mode codes for the text
// console with cursor and scroll. No dependencies.
package tccs_pkg;

  // Default geometry of the character store
  localparam int unsigned ROWS_DEF = 25;
  localparam int unsigned COLS_DEF = 80;

  // Fixed port field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned HEX_W  = 32;
  localparam int unsigned ROW_PW = 5;
  localparam int unsigned COL_PW = 7;

  // Number of nibbles in the printed value
  localparam int unsigned HEX_DIGITS = HEX_W / 4;
  localparam int unsigned NDIG_W     = $clog2(HEX_DIGITS + 1);

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_PUT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HEX  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE   = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

  // Status of the hex digit generator towards the sequencer
  typedef struct packed {
    logic              avail;  // a character is presented
    logic              done;   // generator idle, nothing left to emit
    logic [CHAR_W-1:0] ch;     // presented character
  } hex_stat_t;

  // Outcome of applying the print rule to the presented character
  typedef struct packed {
    logic wr_en;   // printable: store the byte at the cursor
    logic wrap;    // cursor moves to column 0 of the next row
    logic scroll;  // the row move runs off the bottom
  } cur_flags_t;

  // Upper-case ASCII digit for one nibble
  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
    logic [CHAR_W-1:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

### rtl/core/tccs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. No dependencies.
module tccs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tccs_cursor.sv
// Cursor unit: holds the logical cursor, the physical row of the cursor and
// the ring base of the store, and applies the print rule. Uses tccs_pkg.
module tccs_cursor import tccs_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF,
  localparam int unsigned RW = $clog2(ROWS),
  localparam int unsigned CW = $clog2(COLS),
  localparam int unsigned AW = $clog2(ROWS * COLS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [CHAR_W-1:0] char_i,
  output cur_flags_t        flags_o,
  output logic [RW-1:0]     row_o,
  output logic [CW-1:0]     col_o,
  output logic [RW-1:0]     base_o,
  output logic [AW-1:0]     row_addr_o
);

  localparam logic [AW-1:0] COLS_A = AW'(COLS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] prow_q, prow_d;
  logic [RW-1:0] base_q, base_d;
  logic [CW:0]   col_inc;
  logic          printable;
  cur_flags_t    flags;

  // Print rule on the presented byte
  always_comb begin
    printable    = (char_i >= CH_SPACE) && (char_i <= CH_TILDE);
    col_inc      = {1'b0, col_q} + 1'b1;
    flags.wr_en  = printable;
    flags.wrap   = printable ? (col_inc >= (CW+1)'(COLS)) : (char_i == CH_NEWLINE);
    flags.scroll = flags.wrap && (row_q == LAST_ROW);
  end

  // Advance the cursor; a row move always advances the physical row
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    prow_d = prow_q;
    base_d = base_q;
    if (step_i) begin
      if (flags.wrap) begin
        col_d  = '0;
        prow_d = (prow_q == LAST_ROW) ? '0 : prow_q + 1'b1;
        if (flags.scroll) begin
          base_d = (base_q == LAST_ROW) ? '0 : base_q + 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else if (printable) begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      prow_q <= '0;
      base_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      prow_q <= prow_d;
      base_q <= base_d;
    end
  end

  assign flags_o    = flags;
  assign row_o      = row_q;
  assign col_o      = col_q;
  assign base_o     = base_q;
  assign row_addr_o = AW'(prow_q) * COLS_A;

endmodule

### rtl/core/tccs_hexgen.sv
// Hex digit generator: trims leading zero nibbles, then presents "0x" and
// the digits one character per take. Uses tccs_pkg.
module tccs_hexgen import tccs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [HEX_W-1:0] value_i,
  input  logic             take_i,
  output hex_stat_t        stat_o
);

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_TRIM = 2'd1;
  localparam logic [1:0] H_EMIT = 2'd2;
  localparam logic [1:0] PRE_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [HEX_W-1:0]  val_q, val_d;
  logic [NDIG_W-1:0] ndig_q, ndig_d;
  logic [1:0]        pre_q, pre_d;
  logic [3:0]        top_nib;

  assign top_nib = val_q[HEX_W-1 -: 4];

  // Trim one nibble a cycle, then emit on each take
  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    ndig_d  = ndig_q;
    pre_d   = pre_q;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          val_d   = value_i;
          ndig_d  = NDIG_W'(HEX_DIGITS);
          pre_d   = '0;
          state_d = H_TRIM;
        end
      end
      H_TRIM: begin
        if ((ndig_q > NDIG_W'(1)) && (top_nib == 4'd0)) begin
          val_d  = val_q << 4;
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = H_EMIT;
        end
      end
      H_EMIT: begin
        if (take_i) begin
          if (pre_q != PRE_DONE) begin
            pre_d = pre_q + 1'b1;
          end else begin
            val_d  = val_q << 4;
            ndig_d = ndig_q - 1'b1;
            if (ndig_q == NDIG_W'(1)) begin
              state_d = H_IDLE;
            end
          end
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      ndig_q  <= '0;
      pre_q   <= '0;
    end else begin
      state_q <= state_d;
      ndig_q  <= ndig_d;
      pre_q   <= pre_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // Present prefix characters, then the top nibble
  always_comb begin
    stat_o.avail = (state_q == H_EMIT);
    stat_o.done  = (state_q == H_IDLE);
    case (pre_q)
      2'd0:    stat_o.ch = CH_ZERO;
      2'd1:    stat_o.ch = CH_LOWER_X;
      default: stat_o.ch = hex_ascii(top_nib);
    endcase
  end

endmodule

### rtl/core/text_console_cursor_scroll_top.sv
// Top level of the text console with cursor and scroll: sequencer, store and
// output register. Uses tccs_pkg, tccs_ram, tccs_cursor and tccs_hexgen.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) takes one command beat: mode,
//   char_code, hex_value, read_row, read_col. Output channel (out_valid_o /
//   out_ready_i) returns one result beat per command: cell_char, cursor
//   position after the command, and the scroll flag.
//   The store is a ring of ROWS rows in one RAM; a scroll advances the ring
//   base and blanks one row, cell by cell, through the single write port.
//   Work per command, from input beat to result ready:
//     write character  store the byte, plus a row blank on a scroll
//     print hex        trim zero nibbles, then store each character
//                      (up to 10 characters), plus a row blank per scroll
//     read cell        read address, then registered RAM read
//     unused mode      no store access
//   One command is in flight at a time; in_ready_o is high only when idle.
//   The result sits in an output register, so a new command is taken while
//   the previous result waits; a finished command holds until that register
//   frees.
//   After reset the store is swept to spaces, ROWS*COLS cells (2000 at the
//   default size), with in_ready_o low; the cursor starts at row 0, column 0.
module text_console_cursor_scroll_top import tccs_pkg::*; #(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [HEX_W-1:0]  hex_value_i,
  input  logic [ROW_PW-1:0] read_row_i,
  input  logic [COL_PW-1:0] read_col_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] cell_char_o,
  output logic [ROW_PW-1:0] cursor_row_o,
  output logic [COL_PW-1:0] cursor_col_o,
  output logic              scrolled_o
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = $clog2(COLS);
  localparam int unsigned AW = $clog2(CELLS);
  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PUT  = 4'd2;
  localparam logic [3:0] S_SCRL = 4'd3;
  localparam logic [3:0] S_HEX  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_RD3  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic              hexm_q, hexm_d;
  logic              sc_q, sc_d;
  logic [ROW_PW-1:0] rr_q, rr_d;
  logic [COL_PW-1:0] rc_q, rc_d;
  logic [RW-1:0]     rphys_q, rphys_d;
  logic              rin_q, rin_d;
  logic [CHAR_W-1:0] cell_q, cell_d;

  logic              ov_q, ov_d;
  logic [CHAR_W-1:0] ocell_q, ocell_d;
  logic [ROW_PW-1:0] orow_q, orow_d;
  logic [COL_PW-1:0] ocol_q, ocol_d;
  logic              osc_q, osc_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  logic              cur_step;
  cur_flags_t        cur_flags;
  logic [RW-1:0]     cur_row, cur_base;
  logic [CW-1:0]     cur_col;
  logic [AW-1:0]     row_addr;

  logic              hex_start, hex_take;
  hex_stat_t         hex_stat;

  logic [RW:0]       rsum;

  tccs_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tccs_cursor #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_cursor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (cur_step),
    .char_i     (ch_q),
    .flags_o    (cur_flags),
    .row_o      (cur_row),
    .col_o      (cur_col),
    .base_o     (cur_base),
    .row_addr_o (row_addr)
  );

  tccs_hexgen u_hexgen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hex_start),
    .value_i (hex_value_i),
    .take_i  (hex_take),
    .stat_o  (hex_stat)
  );

  // Physical row of the cell to read, through the ring base
  assign rsum = {1'b0, RW'(rr_q)} + {1'b0, cur_base};

  // Read address of the cell
  assign ram_raddr = AW'(rphys_q) * COLS_A + AW'(rc_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    ch_d    = ch_q;
    hexm_d  = hexm_q;
    sc_d    = sc_q;
    rr_d    = rr_q;
    rc_d    = rc_q;
    rphys_d = rphys_q;
    rin_d   = rin_q;
    cell_d  = cell_q;
    ocell_d = ocell_q;
    orow_d  = orow_q;
    ocol_d  = ocol_q;
    osc_d   = osc_q;
    ov_d    = ov_q && !out_ready_i;

    ram_we    = 1'b0;
    ram_waddr = row_addr + AW'(cur_col);
    ram_wdata = ch_q;
    ram_re    = 1'b0;
    cur_step  = 1'b0;
    hex_start = 1'b0;
    hex_take  = 1'b0;

    unique case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = CH_SPACE;
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          sc_d   = 1'b0;
          cell_d = '0;
          hexm_d = 1'b0;
          ch_d   = char_code_i;
          rr_d   = read_row_i;
          rc_d   = read_col_i;
          unique case (mode_i)
            MODE_PUT:  state_d = S_PUT;
            MODE_HEX: begin
              hexm_d    = 1'b1;
              hex_start = 1'b1;
              state_d   = S_HEX;
            end
            MODE_READ: state_d = S_RD1;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        cur_step = 1'b1;
        ram_we   = cur_flags.wr_en;
        if (cur_flags.scroll) begin
          sc_d    = 1'b1;
          cnt_d   = '0;
          state_d = S_SCRL;
        end else begin
          state_d = hexm_q ? S_HEX : S_DONE;
        end
      end
      S_SCRL: begin
        // Blank the row that has just become the bottom row
        ram_we    = 1'b1;
        ram_waddr = row_addr + AW'(cnt_q);
        ram_wdata = CH_SPACE;
        if (cnt_q == CW'(COLS - 1)) begin
          state_d = hexm_q ? S_HEX : S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_HEX: begin
        if (hex_stat.avail) begin
          ch_d     = hex_stat.ch;
          hex_take = 1'b1;
          state_d  = S_PUT;
        end else if (hex_stat.done) begin
          state_d = S_DONE;
        end
      end
      S_RD1: begin
        rin_d   = ({2'b00, rr_q} < 7'(ROWS)) && ({1'b0, rc_q} < 8'(COLS));
        rphys_d = (rsum >= (RW+1)'(ROWS)) ? RW'(rsum - (RW+1)'(ROWS)) : RW'(rsum);
        state_d = S_RD2;
      end
      S_RD2: begin
        ram_re  = rin_q;
        state_d = S_RD3;
      end
      S_RD3: begin
        cell_d  = rin_q ? ram_rdata : '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ocell_d = cell_q;
          orow_d  = ROW_PW'(cur_row);
          ocol_d  = COL_PW'(cur_col);
          osc_d   = sc_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
      hexm_q  <= 1'b0;
      sc_q    <= 1'b0;
      rin_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      hexm_q  <= hexm_d;
      sc_q    <= sc_d;
      rin_q   <= rin_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    rr_q    <= rr_d;
    rc_q    <= rc_d;
    rphys_q <= rphys_d;
    cell_q  <= cell_d;
    ocell_q <= ocell_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    osc_q   <= osc_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = ov_q;
  assign cell_char_o  = ocell_q;
  assign cursor_row_o = orow_q;
  assign cursor_col_o = ocol_q;
  assign scrolled_o   = osc_q;

  // A taken command always leaves the idle state
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("command beat taken but sequencer stayed idle");

  // Cursor stays inside the store
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((RW+1)'(cur_row) < (RW+1)'(ROWS)) && ((CW+1)'(cur_col) < (CW+1)'(COLS)))
    else $error("cursor left the store");

  // The store is written only while a command or the reset sweep runs
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !ram_we)
    else $error("store written while no command in progress");

  // A hex character is taken only when the generator presents one
  a_hex_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_take |-> (hex_stat.avail && !hex_stat.done))
    else $error("hex character taken while none presented");

endmodule

### sim/testbench.sv
// Self-checking testbench for text_console_cursor_scroll_top: a scoreboard class keeps
// its own copy of the screen and cursor and predicts every result beat.
// Depends on tccs_pkg and the console RTL only.
`timescale 1ns / 100ps

module testbench;
  import tccs_pkg::*;

  localparam int unsigned SCREEN_ROWS  = ROWS_DEF;
  localparam int unsigned SCREEN_COLS  = COLS_DEF;
  localparam int unsigned QUIET_LIMIT  = 8000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned PHASE_ITEMS  = 345;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] ch;
    logic [HEX_W-1:0]  hexval;
    logic [ROW_PW-1:0] rrow;
    logic [COL_PW-1:0] rcol;
  } console_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic [ROW_PW-1:0] crow;
    logic [COL_PW-1:0] ccol;
    logic              scrolled;
  } console_result_t;

  // Screen model and queue of predicted result beats
  class console_scoreboard;
    logic [CHAR_W-1:0] screen [SCREEN_ROWS][SCREEN_COLS];
    int unsigned cur_row;
    int unsigned cur_col;
    console_result_t expected_q[$];
    int unsigned fail_count;

    function new();
      foreach (screen[r, c]) screen[r][c] = CH_SPACE;
      cur_row = 0;
      cur_col = 0;
      fail_count = 0;
    endfunction

    // Print one byte at the cursor; report whether the screen scrolled
    function bit put_glyph(logic [CHAR_W-1:0] ch);
      bit next_row;
      next_row = 1'b0;
      if (ch >= CH_SPACE && ch <= CH_TILDE) begin
        screen[cur_row][cur_col] = ch;
        cur_col++;
      end
      if (cur_col >= SCREEN_COLS || ch == CH_NEWLINE) begin
        cur_col = 0;
        cur_row++;
        next_row = 1'b1;
      end
      if (next_row && cur_row >= SCREEN_ROWS) begin
        for (int r = 0; r < SCREEN_ROWS - 1; r++)
          for (int c = 0; c < SCREEN_COLS; c++) screen[r][c] = screen[r + 1][c];
        for (int c = 0; c < SCREEN_COLS; c++) screen[SCREEN_ROWS - 1][c] = CH_SPACE;
        cur_row = SCREEN_ROWS - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // "0x" then the significant nibbles, most significant first
    function bit print_hex(logic [HEX_W-1:0] v);
      string digit_chars;
      int n;
      bit sc;
      digit_chars = "0123456789ABCDEF";
      n = HEX_DIGITS;
      while (n > 1 && v[4*(n-1) +: 4] == 4'd0) n--;
      sc = put_glyph(CH_ZERO);
      sc |= put_glyph(CH_LOWER_X);
      for (int i = n - 1; i >= 0; i--) sc |= put_glyph(digit_chars[v[4*i +: 4]]);
      return sc;
    endfunction

    function void note_command(console_cmd_t c);
      console_result_t r;
      r = '0;
      case (c.mode)
        MODE_PUT:  r.scrolled = put_glyph(c.ch);
        MODE_HEX:  r.scrolled = print_hex(c.hexval);
        MODE_READ: begin
          if (c.rrow < SCREEN_ROWS && c.rcol < SCREEN_COLS) r.glyph = screen[c.rrow][c.rcol];
        end
        default: ;
      endcase
      r.crow = ROW_PW'(cur_row);
      r.ccol = COL_PW'(cur_col);
      expected_q.push_back(r);
    endfunction

    function void report_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    function void check_result(console_result_t got);
      console_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat: char %0d row %0d col %0d scrolled %0d",
                 $time, got.glyph, got.crow, got.ccol, got.scrolled);
        fail_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      report_field("cell_char", exp_r.glyph, got.glyph);
      report_field("cursor_row", exp_r.crow, got.crow);
      report_field("cursor_col", exp_r.ccol, got.ccol);
      report_field("scrolled", exp_r.scrolled, got.scrolled);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [MODE_W-1:0] mode_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [HEX_W-1:0]  hex_value_i = '0;
  logic [ROW_PW-1:0] read_row_i = '0;
  logic [COL_PW-1:0] read_col_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CHAR_W-1:0] cell_char_o;
  logic [ROW_PW-1:0] cursor_row_o;
  logic [COL_PW-1:0] cursor_col_o;
  logic              scrolled_o;

  console_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  text_console_cursor_scroll_top #(
    .ROWS(SCREEN_ROWS),
    .COLS(SCREEN_COLS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .hex_value_i  (hex_value_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_char_o  (cell_char_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic console_cmd_t pack_cmd(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                                            logic [HEX_W-1:0] hexval, logic [ROW_PW-1:0] rrow,
                                            logic [COL_PW-1:0] rcol);
    console_cmd_t c;
    c.mode = mode;
    c.ch = ch;
    c.hexval = hexval;
    c.rrow = rrow;
    c.rcol = rcol;
    return c;
  endfunction

  // Mostly printable text and newlines, some hex, reads near the cursor, a little noise
  function automatic console_cmd_t random_command(int unsigned near_row);
    console_cmd_t c;
    int unsigned pick;
    c.mode = MODE_W'($urandom);
    c.ch = CHAR_W'($urandom);
    c.hexval = $urandom;
    c.rrow = ROW_PW'($urandom);
    c.rcol = COL_PW'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      c.mode = MODE_PUT;
      pick = $urandom_range(99);
      if (pick < 60) c.ch = CHAR_W'($urandom_range(CH_TILDE, CH_SPACE));
      else if (pick < 80) c.ch = CH_NEWLINE;
      else if (pick < 90) begin
        if ($urandom_range(1)) c.ch = CHAR_W'($urandom_range(CH_SPACE - 1));
        else c.ch = CHAR_W'($urandom_range(255, CH_TILDE + 1));
      end
    end else if (pick < 70) begin
      c.mode = MODE_HEX;
      if ($urandom_range(1)) c.hexval = $urandom >> $urandom_range(31);
    end else if (pick < 95) begin
      c.mode = MODE_READ;
      pick = $urandom_range(99);
      if (pick < 45) begin
        c.rrow = ROW_PW'(near_row);
        c.rcol = COL_PW'($urandom_range(SCREEN_COLS - 1));
      end else if (pick < 80) begin
        c.rrow = ROW_PW'($urandom_range(SCREEN_ROWS - 1));
        c.rcol = COL_PW'($urandom_range(SCREEN_COLS - 1));
      end
    end else begin
      c.mode = MODE_UNUSED;
    end
    return c;
  endfunction

  // Offer one beat from a falling edge, hold it until taken, return at a falling edge
  task automatic drive_command(console_cmd_t c);
    in_valid_i  <= 1'b1;
    mode_i      <= c.mode;
    char_code_i <= c.ch;
    hex_value_i <= c.hexval;
    read_row_i  <= c.rrow;
    read_col_i  <= c.rcol;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(c);
    @(negedge clk_i);
  endtask

  // Drop valid for a random number of cycles
  task automatic pause_sender();
    int unsigned n;
    n = 0;
    while (n < 40 && $urandom_range(99) < send_idle_pct) n++;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Receiver: random stalls, and one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(console_result_t'{cell_char_o, cursor_row_o, cursor_col_o, scrolled_o});
  end

  // Watchdog: give up after a long run of cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    console_cmd_t directed[$];
    int unsigned phase_idle[4];
    int unsigned phase_stall[4];
    phase_idle  = '{0, 72, 0, 36};
    phase_stall = '{0, 0, 72, 36};
    sb = new();

    // Field extremes, every mode, unprintable bytes, out-of-range reads
    directed.push_back(pack_cmd(MODE_READ, 8'd0, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, CH_SPACE, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, CH_TILDE, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, 8'd0, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, 8'd31, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, 8'd127, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, 8'd128, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, 8'd255, '1, '1, '1));
    directed.push_back(pack_cmd(MODE_HEX, 8'd0, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_HEX, 8'd0, 32'hFFFF_FFFF, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_HEX, 8'd0, 32'h1, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_HEX, 8'd0, 32'h10, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_HEX, 8'd0, 32'h0000_ABCD, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, CH_NEWLINE, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_PUT, CH_UPPER_A, 32'd0, 5'd0, 7'd0));
    directed.push_back(pack_cmd(MODE_READ, 8'd0, 32'd0, 5'd0, 7'd1));
    directed.push_back(pack_cmd(MODE_READ, 8'd0, 32'd0, 5'd1, 7'd0));
    directed.push_back(pack_cmd(MODE_READ, 8'd0, 32'd0, 5'd24, 7'd79));
    directed.push_back(pack_cmd(MODE_READ, 8'd0, 32'd0, 5'd25, 7'd0));
    directed.push_back(pack_cmd(MODE_READ, 8'd0, 32'd0, 5'd0, 7'd80));
    directed.push_back(pack_cmd(MODE_READ, 8'd0, 32'd0, 5'd31, 7'd127));
    directed.push_back(pack_cmd(MODE_UNUSED, '1, '1, '1, '1));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) drive_command(directed[i]);

    // Random phases; the first one also holds the receiver off for a long stretch
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) hold_request = 1'b1;
      repeat (PHASE_ITEMS) begin
        pause_sender();
        drive_command(random_command(sb.cur_row));
      end
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;

    // Drain outstanding results, then watch for stray beats
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
